/* sv/stream_find_and_replace_core_defines.svh */
// Assertion helpers used by the top-level core, the only block that checks itself.
`ifndef STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sfr_pkg.sv */
package sfr_pkg;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int MAX_JOB = 8;
    localparam int JOB_W   = CHAR_W * MAX_JOB;
    localparam int CAP_W   = 16;
    localparam int REG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUTPUT_CAPACITY    = 3'd4;

    localparam logic [LEN_W-1:0] REPL_LEN_MAX = 4'd8;
    localparam logic [CAP_W-1:0] DROP_SAT     = 16'hFFFF;
    localparam logic [CAP_W-1:0] CAP_RESET    = 16'd31;

    // One unit of work for the back end: up to eight characters, first in the low byte.
    typedef struct packed {
        logic [JOB_W-1:0] chars;
        logic [LEN_W-1:0] num;
        logic             last;
    } t_job;

    typedef struct packed {
        logic [REG_W-1:0] pattern;
        logic [LEN_W-1:0] pattern_len;
        logic [REG_W-1:0] repl;
        logic [LEN_W-1:0] repl_len;
        logic [CAP_W-1:0] capacity;
        logic             clear_pending;
    } t_cfg;

endpackage

/* sv/sfr_regs.sv */
module sfr_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::REG_W-1:0]  pwdata,
    output logic [sfr_pkg::REG_W-1:0]  prdata,
    output logic                      pready,
    output sfr_pkg::t_cfg             o_cfg
);

    logic [sfr_pkg::REG_W-1:0] r_pattern;
    logic [sfr_pkg::LEN_W-1:0] r_plen;
    logic [sfr_pkg::REG_W-1:0] r_repl;
    logic [sfr_pkg::LEN_W-1:0] r_rlen;
    logic [sfr_pkg::CAP_W-1:0] r_cap;
    logic                      wr_en;
    logic [sfr_pkg::IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[sfr_pkg::ADDR_W-1:sfr_pkg::ADDR_W-sfr_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= sfr_pkg::LEN_W'(1);
            r_repl    <= '0;
            r_rlen    <= '0;
            r_cap     <= sfr_pkg::CAP_RESET;
        end else if (wr_en) begin
            case (idx)
                sfr_pkg::REG_PATTERN_BYTES:      r_pattern <= pwdata;
                sfr_pkg::REG_PATTERN_LENGTH:     r_plen    <= pwdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  r_repl    <= pwdata;
                sfr_pkg::REG_REPLACEMENT_LENGTH: r_rlen    <= pwdata[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_OUTPUT_CAPACITY:    r_cap     <= pwdata[sfr_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            sfr_pkg::REG_PATTERN_BYTES:      prdata = r_pattern;
            sfr_pkg::REG_PATTERN_LENGTH:     prdata = sfr_pkg::REG_W'(r_plen);
            sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = r_repl;
            sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = sfr_pkg::REG_W'(r_rlen);
            sfr_pkg::REG_OUTPUT_CAPACITY:    prdata = sfr_pkg::REG_W'(r_cap);
            default:                         prdata = '0;
        endcase
    end

    // A new pattern or pattern length invalidates whatever is waiting in the window.
    assign o_cfg.pattern       = r_pattern;
    assign o_cfg.pattern_len   = r_plen;
    assign o_cfg.repl          = r_repl;
    assign o_cfg.repl_len      = r_rlen;
    assign o_cfg.capacity      = r_cap;
    assign o_cfg.clear_pending = wr_en && (idx == sfr_pkg::REG_PATTERN_BYTES ||
                                           idx == sfr_pkg::REG_PATTERN_LENGTH);

endmodule

/* sv/sfr_front.sv */
module sfr_front #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sfr_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic [sfr_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_last,
    output logic                       o_stall,
    input  logic                       i_full,
    output logic                       o_push,
    output sfr_pkg::t_job              o_job
);

    localparam int WIN_W = sfr_pkg::CHAR_W * MAX_PATTERN;
    localparam int SH_W  = sfr_pkg::LEN_W + $clog2(sfr_pkg::CHAR_W);
    localparam logic [sfr_pkg::LEN_W-1:0] MAXP = sfr_pkg::LEN_W'(MAX_PATTERN);

    logic [WIN_W-1:0]          r_win;
    logic [sfr_pkg::LEN_W-1:0] r_cnt;
    logic [WIN_W-1:0]          n_win;
    logic [sfr_pkg::LEN_W-1:0] n_cnt;

    logic [WIN_W-1:0]          win;
    logic [2*WIN_W-1:0]        wpad;
    logic [sfr_pkg::LEN_W-1:0] cnt;
    logic [sfr_pkg::LEN_W-1:0] plen;
    logic [sfr_pkg::LEN_W-1:0] rlen;
    logic [sfr_pkg::LEN_W-1:0] lead;
    logic [MAX_PATTERN-1:0]    ok;
    logic                      full_match;
    logic [SH_W-1:0]           shamt;
    logic                      accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        if (i_cfg.pattern_len == '0) begin
            plen = sfr_pkg::LEN_W'(1);
        end else if (i_cfg.pattern_len > MAXP) begin
            plen = MAXP;
        end else begin
            plen = i_cfg.pattern_len;
        end
        rlen = (i_cfg.repl_len > sfr_pkg::REPL_LEN_MAX) ? sfr_pkg::REPL_LEN_MAX
                                                        : i_cfg.repl_len;
    end

    // Append the new character behind the pending ones.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            win[sfr_pkg::CHAR_W*j +: sfr_pkg::CHAR_W] =
                (r_cnt == sfr_pkg::LEN_W'(j)) ? i_char
                                              : r_win[sfr_pkg::CHAR_W*j +: sfr_pkg::CHAR_W];
        end
        cnt  = r_cnt + sfr_pkg::LEN_W'(1);
        wpad = {{WIN_W{1'b0}}, win};
    end

    // ok[k]: the window from offset k on agrees with the start of the pattern.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            ok[k] = 1'b1;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if ((sfr_pkg::LEN_W'(i) < plen) && (sfr_pkg::LEN_W'(k + i) < cnt) &&
                    (wpad[sfr_pkg::CHAR_W*(k+i) +: sfr_pkg::CHAR_W] !=
                     i_cfg.pattern[sfr_pkg::CHAR_W*i +: sfr_pkg::CHAR_W])) begin
                    ok[k] = 1'b0;
                end
            end
        end
    end

    // Leading characters that can no longer start an occurrence leave as literals.
    always_comb begin
        lead = cnt;
        for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
            if ((sfr_pkg::LEN_W'(k) < cnt) && ok[k]) begin
                lead = sfr_pkg::LEN_W'(k);
            end
        end
        full_match = (lead == '0) && (cnt == plen);
        shamt      = SH_W'(lead) * SH_W'(sfr_pkg::CHAR_W);
        n_win      = win >> shamt;
        n_cnt      = (full_match || i_last) ? '0 : cnt - lead;
    end

    always_comb begin
        o_job.last = i_last;
        if (full_match) begin
            o_job.chars = i_cfg.repl;
            o_job.num   = rlen;
        end else begin
            o_job.chars = sfr_pkg::JOB_W'(win);
            o_job.num   = i_last ? cnt : lead;
        end
        o_push = accept && (o_job.num != '0 || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg.clear_pending) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

/* sv/sfr_fifo.sv */
module sfr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output sfr_pkg::t_job o_data,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfr_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/sfr_back.sv */
module sfr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sfr_pkg::CAP_W-1:0]  i_capacity,
    input  logic                       i_empty,
    input  sfr_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [sfr_pkg::CHAR_W-1:0] o_char,
    output logic                       o_char_valid,
    output logic                       o_last,
    output logic [sfr_pkg::CAP_W-1:0]  o_dropped
);

    // Job being walked out
    logic                      r_act,   n_act;
    logic [sfr_pkg::JOB_W-1:0] r_chars, n_chars;
    logic [sfr_pkg::LEN_W-1:0] r_rem,   n_rem;
    logic                      r_cv,    n_cv;
    logic                      r_last,  n_last;
    logic [sfr_pkg::CAP_W-1:0] r_drop,  n_drop;
    // Per-text bookkeeping
    logic [sfr_pkg::CAP_W-1:0] r_emit,  n_emit;
    logic [sfr_pkg::CAP_W-1:0] r_dtot,  n_dtot;
    // Output register
    logic                      r_ov,    n_ov;
    logic [sfr_pkg::CHAR_W-1:0] r_och,  n_och;
    logic                      r_ocv,   n_ocv;
    logic                      r_olast, n_olast;
    logic [sfr_pkg::CAP_W-1:0] r_odrop, n_odrop;

    logic                      adv;
    logic [sfr_pkg::CAP_W-1:0] avail;
    logic [sfr_pkg::LEN_W-1:0] stored;
    logic [sfr_pkg::LEN_W-1:0] lost;
    logic [sfr_pkg::CAP_W:0]   dsum;
    logic [sfr_pkg::CAP_W-1:0] dnew;

    assign adv   = !r_ov || !i_stall;
    assign o_pop = !i_empty && (!r_act || (adv && r_rem == sfr_pkg::LEN_W'(1)));

    // Split the job into characters that still fit and characters that are lost.
    always_comb begin
        avail  = (r_emit < i_capacity) ? i_capacity - r_emit : '0;
        stored = (avail < sfr_pkg::CAP_W'(i_job.num)) ? avail[sfr_pkg::LEN_W-1:0]
                                                      : i_job.num;
        lost   = i_job.num - stored;
        dsum   = {1'b0, r_dtot} + (sfr_pkg::CAP_W+1)'(lost);
        dnew   = dsum[sfr_pkg::CAP_W] ? sfr_pkg::DROP_SAT : dsum[sfr_pkg::CAP_W-1:0];
    end

    always_comb begin
        n_act   = r_act;
        n_chars = r_chars;
        n_rem   = r_rem;
        n_cv    = r_cv;
        n_last  = r_last;
        n_drop  = r_drop;
        n_emit  = r_emit;
        n_dtot  = r_dtot;
        n_ov    = r_ov;
        n_och   = r_och;
        n_ocv   = r_ocv;
        n_olast = r_olast;
        n_odrop = r_odrop;

        if (adv) begin
            n_ov = r_act;
            if (r_act) begin
                n_och   = r_cv ? r_chars[sfr_pkg::CHAR_W-1:0] : '0;
                n_ocv   = r_cv;
                n_olast = r_last && (r_rem == sfr_pkg::LEN_W'(1));
                n_odrop = n_olast ? r_drop : '0;
                n_chars = r_chars >> sfr_pkg::CHAR_W;
                n_rem   = r_rem - sfr_pkg::LEN_W'(1);
                if (r_rem == sfr_pkg::LEN_W'(1)) begin
                    n_act = 1'b0;
                end
            end
        end

        // A job with nothing stored only updates the counts, unless it ends the text.
        if (o_pop) begin
            n_act   = (stored != '0) || i_job.last;
            n_chars = i_job.chars;
            n_rem   = (stored != '0) ? stored : sfr_pkg::LEN_W'(1);
            n_cv    = (stored != '0);
            n_last  = i_job.last;
            n_drop  = dnew;
            if (i_job.last) begin
                n_emit = '0;
                n_dtot = '0;
            end else begin
                n_emit = r_emit + sfr_pkg::CAP_W'(stored);
                n_dtot = dnew;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_ov   <= 1'b0;
            r_emit <= '0;
            r_dtot <= '0;
        end else begin
            r_act  <= n_act;
            r_ov   <= n_ov;
            r_emit <= n_emit;
            r_dtot <= n_dtot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        r_rem   <= n_rem;
        r_cv    <= n_cv;
        r_last  <= n_last;
        r_drop  <= n_drop;
        r_och   <= n_och;
        r_ocv   <= n_ocv;
        r_olast <= n_olast;
        r_odrop <= n_odrop;
    end

    assign o_valid      = r_ov;
    assign o_char       = r_och;
    assign o_char_valid = r_ocv;
    assign o_last       = r_olast;
    assign o_dropped    = r_odrop;

endmodule

/* sv/stream_find_and_replace_core.sv */
// Streaming find-and-replace. One text character is taken per cycle unless the
// input stalls; the front end compares the pending window plus the new character
// against every offset of the pattern combinationally and turns each character into
// a job (literals, a replacement, or nothing yet) that goes into a QUEUE_DEPTH-entry
// queue. The back end walks each job out through an output register at one result
// per cycle unless the output stalls, so an item yields as many results as characters
// it stores (0 to 8), or one when it ends a text and stores none; a character that
// only extends a partial match yields no job and never enters the queue. Input stalls
// only when the queue is full, which makes the output side the limit on sustained
// rate. The first result of an item passes through the queue, job and output registers.
// Characters beyond output_capacity are counted, not sent, and the final result of a
// text (in_last) carries that count. Program the registers only while the block is
// idle; writing the pattern or its length throws away pending characters.
`include "stream_find_and_replace_core_defines.svh"

module stream_find_and_replace_core #(
    parameter int MAX_PATTERN = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Text in
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sfr_pkg::CHAR_W-1:0] i_in_char,
    input  logic                       i_in_last,
    // Text out
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sfr_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_char_valid,
    output logic                       o_out_last,
    output logic [sfr_pkg::CAP_W-1:0]  o_dropped_count,
    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::REG_W-1:0]  pwdata,
    output logic [sfr_pkg::REG_W-1:0]  prdata,
    output logic                       pready
);

    sfr_pkg::t_cfg cfg;
    sfr_pkg::t_job push_job;
    sfr_pkg::t_job pop_job;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    sfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .i_char  (i_in_char),
        .i_last  (i_in_last),
        .o_stall (o_in_stall),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (push_job)
    );

    sfr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_job),
        .o_empty (q_empty)
    );

    sfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (cfg.capacity),
        .i_empty      (q_empty),
        .i_job        (pop_job),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_char       (o_out_char),
        .o_char_valid (o_char_valid),
        .o_last       (o_out_last),
        .o_dropped    (o_dropped_count)
    );

    `SFR_ASSERT_NOW(a_job_not_empty, i_clk, i_rst_n,
        pop, (pop_job.num != '0) || pop_job.last,
        "queued job carries no characters and does not end the text")
    `SFR_ASSERT_NOW(a_drop_only_final, i_clk, i_rst_n,
        o_out_valid && !o_out_last, o_dropped_count == '0,
        "drop count on a result that is not final")
    `SFR_ASSERT_NOW(a_empty_only_final, i_clk, i_rst_n,
        o_out_valid && !o_char_valid, o_out_last,
        "result without a character that is not final")
    `SFR_ASSERT_NEXT(a_last_queued, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in_last, !q_empty,
        "end of text produced no job")

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfr_pkg::*;

    localparam int LATENCY_WAIT     = 8;
    localparam int WATCHDOG_LIMIT   = 6000;
    localparam int LONG_HOLD        = 400;
    localparam int FILL_ITEMS       = 24;
    localparam int MAX_STEP_RESULTS = 8;
    localparam int N_PLAN           = 43;

    localparam logic [IDX_W-1:0] REG_UNMAPPED_A = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              stored;
        logic              last;
        logic [CAP_W-1:0]  dropped;
    } text_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [IDX_W-1:0] idx;
        logic [REG_W-1:0] data;
        logic             last;
        logic             typed;
        text_result_t     want;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [CHAR_W-1:0]    i_in_char   = '0;
    logic                 i_in_last   = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CHAR_W-1:0]    o_out_char;
    logic                 o_char_valid;
    logic                 o_out_last;
    logic [CAP_W-1:0]     o_dropped_count;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_W-1:0]    paddr       = '0;
    logic [REG_W-1:0]     pwdata      = '0;
    logic [REG_W-1:0]     prdata;
    logic                 pready;

    // Register shadow and rewrite state
    logic [REG_W-1:0]     cfg_pattern  = '0;
    logic [LEN_W-1:0]     cfg_pat_len  = 4'd1;
    logic [REG_W-1:0]     cfg_repl     = '0;
    logic [LEN_W-1:0]     cfg_repl_len = '0;
    logic [CAP_W-1:0]     cfg_capacity = CAP_RESET;
    logic [CHAR_W-1:0]    held_chars [MAX_JOB];
    int unsigned          held_n    = 0;
    int unsigned          stored_n  = 0;
    int unsigned          dropped_n = 0;
    text_result_t         step_results [$];
    text_result_t         rewritten_q [$];
    text_result_t         head;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int n_err          = 0;
    int items_sent     = 0;
    int texts_sent     = 0;
    int texts_left     = 0;
    int configs_used   = 0;
    int results_seen   = 0;
    int drops_seen     = 0;

    // Directed stimulus; rows with typed set carry their expected result
    localparam plan_row_t DIR_PLAN [N_PLAN] = '{
        '{ROW_ITEM,  '0, 64'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 16'd0}},
        '{ROW_ITEM,  '0, 64'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd0}},
        '{ROW_WRITE, REG_PATTERN_BYTES,      64'h636261, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LENGTH,     64'd3,      1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPLACEMENT_BYTES,  64'h5958,   1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPLACEMENT_LENGTH, 64'd2,      1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h61, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h62, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h61, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h62, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h63, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h64, 1'b1, 1'b0, '0},
        // leave a partial match pending, then rewrite the pattern under it
        '{ROW_ITEM,  '0, 64'h61, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h62, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LENGTH,     64'd2,      1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h7A, 1'b1, 1'b0, '0},
        // zero pattern length acts as one, oversized replacement length as eight
        '{ROW_WRITE, REG_PATTERN_LENGTH,     64'd0,      1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPLACEMENT_BYTES,  '1,         1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPLACEMENT_LENGTH, 64'd15,     1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h61, 1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_BYTES,      64'd0,      1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LENGTH,     64'd15,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_OUTPUT_CAPACITY,    64'd0,      1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h71, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h72, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd2}},
        '{ROW_WRITE, REG_OUTPUT_CAPACITY,    64'hFFFF,   1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h00, 1'b1, 1'b0, '0},
        '{ROW_WRITE, REG_PATTERN_LENGTH,     64'd1,      1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPLACEMENT_LENGTH, 64'd0,      1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_OUTPUT_CAPACITY,    64'd2,      1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h78, 1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h79, 1'b0, 1'b0, '0},
        // shrink the capacity below what this text already stored
        '{ROW_WRITE, REG_OUTPUT_CAPACITY,    64'd1,      1'b0, 1'b0, '0},
        '{ROW_ITEM,  '0, 64'h7A, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd1}},
        '{ROW_WRITE, REG_UNMAPPED_A,         64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_UNMAPPED_B,         '1,         1'b0, 1'b0, '0}
    };

    stream_find_and_replace_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_char       (i_in_char),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_out_last      (o_out_last),
        .o_dropped_count (o_dropped_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned match_len();
        int unsigned n;
        n = cfg_pat_len;
        if (n == 0) n = 1;
        if (n > MAX_JOB) n = MAX_JOB;
        return n;
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        case (idx)
            REG_PATTERN_BYTES: begin
                cfg_pattern = val;
                held_n = 0;
            end
            REG_PATTERN_LENGTH: begin
                cfg_pat_len = val[LEN_W-1:0];
                held_n = 0;
            end
            REG_REPLACEMENT_BYTES:  cfg_repl = val;
            REG_REPLACEMENT_LENGTH: cfg_repl_len = val[LEN_W-1:0];
            REG_OUTPUT_CAPACITY:    cfg_capacity = val[CAP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void store_char(input logic [CHAR_W-1:0] c);
        if (stored_n < cfg_capacity && step_results.size() < MAX_STEP_RESULTS) begin
            step_results.push_back('{ch: c, stored: 1'b1, last: 1'b0, dropped: '0});
            stored_n++;
        end else if (dropped_n < DROP_SAT) begin
            dropped_n++;
        end
    endfunction

    function automatic void drop_front(input int unsigned k);
        if (k > held_n) k = held_n;
        for (int unsigned i = 0; i + k < held_n; i++) held_chars[i] = held_chars[i + k];
        held_n -= k;
    endfunction

    // Emit literals and replacements until the window front is a proper prefix
    function automatic void settle_window();
        int unsigned plen;
        int unsigned cmp;
        int unsigned rlen;
        bit          hit;
        plen = match_len();
        rlen = (cfg_repl_len > REPL_LEN_MAX) ? REPL_LEN_MAX : cfg_repl_len;
        while (held_n > 0) begin
            cmp = (held_n < plen) ? held_n : plen;
            hit = 1'b1;
            for (int unsigned i = 0; i < cmp; i++)
                if (held_chars[i] != cfg_pattern[CHAR_W*i +: CHAR_W]) hit = 1'b0;
            if (hit && held_n >= plen) begin
                for (int unsigned i = 0; i < rlen; i++) store_char(cfg_repl[CHAR_W*i +: CHAR_W]);
                drop_front(plen);
            end else if (hit) begin
                break;
            end else begin
                store_char(held_chars[0]);
                drop_front(1);
            end
        end
    endfunction

    function automatic void rewrite_char(input logic [CHAR_W-1:0] c, input logic l);
        text_result_t tail;
        step_results.delete();
        if (held_n > MAX_JOB - 1) held_n = MAX_JOB - 1;
        held_chars[held_n] = c;
        held_n++;
        settle_window();
        if (l) begin
            // flush what is still pending as literals
            for (int unsigned i = 0; i < held_n; i++) store_char(held_chars[i]);
            held_n = 0;
            if (step_results.size() == 0)
                step_results.push_back('{ch: '0, stored: 1'b0, last: 1'b0, dropped: '0});
            tail = step_results.pop_back();
            tail.last = 1'b1;
            tail.dropped = dropped_n[CAP_W-1:0];
            step_results.push_back(tail);
            stored_n = 0;
            dropped_n = 0;
        end
    endfunction

    function automatic logic [REG_W-1:0] pick_value(input logic [IDX_W-1:0] idx);
        logic [REG_W-1:0]  v;
        logic [CHAR_W-1:0] base;
        v = {$urandom, $urandom};
        base = CHAR_W'($urandom_range(0, 255));
        case (idx)
            REG_PATTERN_BYTES: begin
                // two neighboring letters make overlapping and repeated matches common
                if ($urandom_range(0, 4) != 0)
                    for (int i = 0; i < MAX_JOB; i++)
                        v[CHAR_W*i +: CHAR_W] = base + CHAR_W'($urandom_range(0, 1));
            end
            REG_PATTERN_LENGTH:
                v = ($urandom_range(0, 9) == 0) ? REG_W'($urandom_range(0, 15))
                                                : REG_W'($urandom_range(1, 8));
            REG_REPLACEMENT_LENGTH:
                v = ($urandom_range(0, 9) == 0) ? REG_W'($urandom_range(9, 15))
                                                : REG_W'($urandom_range(0, 8));
            REG_OUTPUT_CAPACITY: begin
                case ($urandom_range(0, 9))
                    0:       v = '0;
                    1:       v = REG_W'(16'hFFFF);
                    default: v = REG_W'($urandom_range(0, 40));
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            n_err++;
        end
    endfunction

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Drop valid and wait out every expected result plus the pipeline depth
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (rewritten_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic send_item(input logic [CHAR_W-1:0] c, input logic l,
                             input logic typed = 1'b0, input text_result_t want = '0);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        i_in_last  <= l;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (l) texts_sent++;
        rewrite_char(c, l);
        if (typed) rewritten_q.push_back(want);
        else foreach (step_results[k]) rewritten_q.push_back(step_results[k]);
    endtask

    task automatic send_text();
        logic [CHAR_W-1:0] text_chars [$];
        logic [IDX_W-1:0]  idx;
        int unsigned       goal;
        int unsigned       plen;
        int unsigned       cut;
        int unsigned       pos;
        bit                tidy;
        goal = $urandom_range(1, 24);
        tidy = ($urandom_range(0, 4) != 0);
        plen = match_len();
        while (text_chars.size() < goal) begin
            case (tidy ? $urandom_range(0, 3) : 3)
                0: for (int i = 0; i < plen; i++)
                       text_chars.push_back(cfg_pattern[CHAR_W*i +: CHAR_W]);
                1: begin
                    cut = $urandom_range(1, plen);
                    for (int i = 0; i < cut; i++)
                        text_chars.push_back(cfg_pattern[CHAR_W*i +: CHAR_W]);
                end
                2: begin
                    pos = $urandom_range(0, plen - 1);
                    text_chars.push_back(cfg_pattern[CHAR_W*pos +: CHAR_W]);
                end
                default: text_chars.push_back(CHAR_W'($urandom));
            endcase
        end
        // now and then rewrite a register partway through the text
        pos = 0;
        if (text_chars.size() > 1 && $urandom_range(0, 7) == 0)
            pos = $urandom_range(1, text_chars.size() - 1);
        foreach (text_chars[i]) begin
            if (pos != 0 && i == pos) begin
                drain_block();
                idx = IDX_W'($urandom_range(0, 7));
                reg_write(idx, pick_value(idx));
            end
            send_item(text_chars[i], i == text_chars.size() - 1);
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int goal);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (items_sent < goal) begin
            if (texts_left == 0) begin
                drain_block();
                for (int r = REG_PATTERN_BYTES; r <= REG_OUTPUT_CAPACITY; r++)
                    reg_write(IDX_W'(r), pick_value(IDX_W'(r)));
                if ($urandom_range(0, 3) == 0) reg_write(REG_UNMAPPED_A, pick_value(REG_UNMAPPED_A));
                texts_left = $urandom_range(1, 4);
                configs_used++;
            end
            send_text();
            texts_left--;
        end
    endtask

    // Receiver: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (rewritten_q.size() == 0) begin
                $error("unexpected item: out_char %0d out_last %0b", o_out_char, o_out_last);
                n_err++;
            end else begin
                head = rewritten_q.pop_front();
                check_field("out_char", head.ch, o_out_char);
                check_field("char_valid", head.stored, o_char_valid);
                check_field("out_last", head.last, o_out_last);
                check_field("dropped_count", head.dropped, o_dropped_count);
                if (head.last) drops_seen += head.dropped;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_PLAN[r]) begin
            if (DIR_PLAN[r].kind == ROW_WRITE) begin
                drain_block();
                reg_write(DIR_PLAN[r].idx, DIR_PLAN[r].data);
            end else begin
                send_item(DIR_PLAN[r].data[CHAR_W-1:0], DIR_PLAN[r].last,
                          DIR_PLAN[r].typed, DIR_PLAN[r].want);
            end
        end

        run_phase(15, 80, 140);
        run_phase(80, 15, 270);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // hold the output side while the sender keeps pushing one long text
        hold_requests++;
        for (int k = 0; k < FILL_ITEMS; k++)
            send_item(CHAR_W'($urandom), k == FILL_ITEMS - 1);
        drain_block();
        run_phase(0, 0, 410);
        drain_block();

        $display("Sent %0d items in %0d texts over %0d random register settings.",
                 items_sent, texts_sent, configs_used);
        $display("Checked %0d output items; %0d characters were reported lost to truncation.",
                 results_seen, drops_seen);
        if (n_err == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
